// File: rtl/pbwm_pkg.sv
// Shared constants and types for the program bank window mapper.
`timescale 1ns / 1ps

package pbwm_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_LEGACY   = 2'd0;
	localparam logic [1:0] CFG_ROM_LOG2 = 2'd1;
	localparam logic [1:0] CFG_RAM_LOG2 = 2'd2;

	// item kinds on the input tuser
	localparam logic OP_REG_WRITE = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;

	// register decode
	localparam logic [15:0] ADDR_ALIAS_FROM = 16'h4120;
	localparam logic [15:0] ADDR_ALIAS_TO   = 16'h4118;
	localparam logic [3:0]  REG_PAGE        = 4'h4;
	localparam logic [7:0]  REG_MODE        = 8'h00;
	localparam logic [7:0]  REG_HIGH_FIRST  = 8'h08;
	localparam logic [7:0]  REG_HIGH_LAST   = 8'h0F;
	localparam logic [7:0]  REG_LOW_FIRST   = 8'h18;
	localparam logic [7:0]  REG_LOW_LAST    = 8'h1F;

	// window modes
	localparam logic [2:0] MODE_32K       = 3'd0;
	localparam logic [2:0] MODE_16K_16K   = 3'd1;
	localparam logic [2:0] MODE_16K_8K_8K = 3'd2;
	localparam logic [2:0] MODE_8K_X4     = 3'd3;

	localparam logic [7:0] LEGACY_LOW_PRESET = 8'hFF;
	localparam int unsigned CHIP_ADDR_W = 24;

	typedef struct packed {
		logic select_ram;
		logic in_prg_space;
		logic reg_written;
	} result_flags_t;

endpackage

// File: rtl/prg_bank_window_mapper_core.sv
// Top level of the program bank window mapper: register decode and address translation.
`timescale 1ns / 1ps

// Program bank window mapper.
// Input stream (s_*): one CPU access per word. tuser = op (0 register write,
// 1 translate); tdata = cpu_addr, write_data.
// Output stream (m_*): one result word per input word, in order. tuser holds
// the flags reg_written, in_prg_space, select_ram; tdata holds chip_addr.
// Config channel (cfg_*): index 0 legacy_v13, 1 rom_size_log2, 2 ram_size_log2;
// always ready; write only while the block is idle. Writing legacy_v13 also
// returns the mode and bank bytes to their reset values, except that with
// legacy on, lower bytes 0 and 4 are preset to 8'hFF.
// Each word passes the input register, then the result register.
// Throughput: one word per clock while the receiver is ready, set by the single
// pass of decode and window selection between the two registers.
// Register writes update the bank state as the word leaves the input
// register, so the following word already sees the new banks.
// When the receiver stalls, the result register holds, the input register
// fills and s_tready drops; nothing is lost or repeated.
// Reset (arst_n low) clears the pipeline, the mode and the bank bytes, and
// loads the configuration reset values (legacy off, both sizes 32K).
module prg_bank_window_mapper_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [15:0] cpu_addr, [23:16] write_data
	input  logic [0:0]  s_tuser,  // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [23:0] chip_addr
	output logic [2:0]  m_tuser,  // [0] reg_written, [1] in_prg_space, [2] select_ram
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import pbwm_pkg::*;

	logic        legacy_q;
	logic [4:0]  rom_log2_q;
	logic [4:0]  ram_log2_q;
	logic [2:0]  mode_q;
	logic [7:0]  bank_high_q [8];
	logic [7:0]  bank_low_q  [8];

	logic        valid_s1;
	logic        op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic          valid_s2;
	result_flags_t flags_s2;
	logic [23:0]   chip_s2;

	logic advance;
	logic cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign advance   = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready  = ~valid_s1 | advance;

	// register write decode
	logic [15:0] waddr;
	logic        reg_hit;
	logic [7:0]  reg_sel;
	logic        wr_mode, wr_high, wr_low;

	always_comb begin
		waddr = addr_s1;
		if (legacy_q && addr_s1 == ADDR_ALIAS_FROM) begin
			waddr = ADDR_ALIAS_TO;
		end
		reg_hit = (op_s1 == OP_REG_WRITE) && (waddr[15:12] == REG_PAGE) && waddr[8];
		reg_sel = waddr[7:0];
		wr_mode = reg_hit && (reg_sel == REG_MODE);
		wr_high = reg_hit && (reg_sel inside {[REG_HIGH_FIRST:REG_HIGH_LAST]});
		wr_low  = reg_hit && (reg_sel inside {[REG_LOW_FIRST:REG_LOW_LAST]});
	end

	// window selection
	logic [2:0]  entry;
	logic [3:0]  shift;
	logic [15:0] bank;
	logic [31:0] full;
	logic [31:0] offset;
	logic        is_ram;
	logic [4:0]  size_log2;
	logic [23:0] mask;
	logic        in_prg;

	always_comb begin
		case (mode_q)
			MODE_32K: begin
				entry = 3'd0;
				shift = 4'd15;
			end
			MODE_16K_16K: begin
				entry = {addr_s1[14], 2'b00};
				shift = 4'd14;
			end
			MODE_16K_8K_8K: begin
				if (!addr_s1[14]) begin
					entry = 3'd0;
					shift = 4'd14;
				end else begin
					entry = {1'b1, addr_s1[13], 1'b0};
					shift = 4'd13;
				end
			end
			MODE_8K_X4: begin
				entry = {addr_s1[14:13], 1'b0};
				shift = 4'd13;
			end
			default: begin
				entry = addr_s1[14:12];
				shift = 4'd12;
			end
		endcase
		bank      = {bank_high_q[entry], bank_low_q[entry]};
		offset    = {16'd0, addr_s1} & ((32'd1 << shift) - 32'd1);
		full      = ({16'd0, bank} << shift) | offset;
		is_ram    = bank_high_q[entry][7];
		size_log2 = is_ram ? ram_log2_q : rom_log2_q;
		if (size_log2 >= 5'(CHIP_ADDR_W)) begin
			mask = '1;
		end else begin
			mask = 24'((32'd1 << size_log2) - 32'd1);
		end
		in_prg = (op_s1 == OP_TRANSLATE) && addr_s1[15];
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser[0];
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2.reg_written  <= reg_hit;
			flags_s2.in_prg_space <= in_prg;
			flags_s2.select_ram   <= in_prg & is_ram;
			chip_s2               <= in_prg ? (full[23:0] & mask) : 24'd0;
		end
	end

	// configuration and bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			legacy_q   <= 1'b0;
			rom_log2_q <= 5'd15;
			ram_log2_q <= 5'd15;
			mode_q     <= 3'd0;
			for (int i = 0; i < 8; i++) begin
				bank_high_q[i] <= 8'd0;
				bank_low_q[i]  <= 8'd0;
			end
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_LEGACY: begin
					legacy_q <= cfg_data[0];
					mode_q   <= 3'd0;
					// legacy presets lower bytes 0 and 4
					for (int i = 0; i < 8; i++) begin
						bank_high_q[i] <= 8'd0;
						bank_low_q[i]  <= (cfg_data[0] && (i == 0 || i == 4)) ?
							LEGACY_LOW_PRESET : 8'd0;
					end
				end
				CFG_ROM_LOG2: rom_log2_q <= cfg_data;
				CFG_RAM_LOG2: ram_log2_q <= cfg_data;
				default: ;
			endcase
		end else if (advance) begin
			if (wr_mode) begin
				mode_q <= data_s1[2:0];
			end
			if (wr_high) begin
				bank_high_q[reg_sel[2:0]] <= data_s1;
			end
			if (wr_low) begin
				bank_low_q[reg_sel[2:0]] <= data_s1;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = chip_s2;
	assign m_tuser  = flags_s2;

	// a word is either a register write or a translate, never both
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("reg_written and in_prg_space both set");

	// outside program space the address and chip select are zero
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata == 24'd0 && !m_tuser[2]))
		else $error("non-zero address outside program space");

	// stalled output with a full input stage blocks intake
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input accepted while pipeline is blocked");

	// legacy enable presets the two lower bank bytes
	a_legacy_preset: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && cfg_index == CFG_LEGACY && cfg_data[0]) |=>
		(bank_low_q[0] == LEGACY_LOW_PRESET && bank_low_q[4] == LEGACY_LOW_PRESET
		&& mode_q == 3'd0))
		else $error("legacy preset not applied");

	// a held result stays put while the receiver stalls
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed under stall");

endmodule
